### rtl/mieu_pkg.sv
// shared types and codes for the integer execute unit
package mieu_pkg;

	localparam logic [1:0] FMT_R = 2'd0;
	localparam logic [1:0] FMT_I = 2'd1;
	localparam logic [1:0] FMT_J = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OVF  = 2'd1;
	localparam logic [1:0] ST_DIV0 = 2'd2;
	localparam logic [1:0] ST_UNK  = 2'd3;

	// r-type funct codes
	localparam logic [5:0] F_SLL   = 6'd0;
	localparam logic [5:0] F_SRL   = 6'd2;
	localparam logic [5:0] F_SRA   = 6'd3;
	localparam logic [5:0] F_SLLV  = 6'd4;
	localparam logic [5:0] F_SRLV  = 6'd6;
	localparam logic [5:0] F_SRAV  = 6'd7;
	localparam logic [5:0] F_JR    = 6'd8;
	localparam logic [5:0] F_JALR  = 6'd9;
	localparam logic [5:0] F_MFHI  = 6'd16;
	localparam logic [5:0] F_MTHI  = 6'd17;
	localparam logic [5:0] F_MFLO  = 6'd18;
	localparam logic [5:0] F_MTLO  = 6'd19;
	localparam logic [5:0] F_MULT  = 6'd24;
	localparam logic [5:0] F_MULTU = 6'd25;
	localparam logic [5:0] F_DIV   = 6'd26;
	localparam logic [5:0] F_DIVU  = 6'd27;
	localparam logic [5:0] F_ADD   = 6'd32;
	localparam logic [5:0] F_ADDU  = 6'd33;
	localparam logic [5:0] F_SUB   = 6'd34;
	localparam logic [5:0] F_SUBU  = 6'd35;
	localparam logic [5:0] F_AND   = 6'd36;
	localparam logic [5:0] F_OR    = 6'd37;
	localparam logic [5:0] F_XOR   = 6'd38;
	localparam logic [5:0] F_NOR   = 6'd39;
	localparam logic [5:0] F_SLT   = 6'd42;
	localparam logic [5:0] F_SLTU  = 6'd43;

	// i-type and j-type opcodes
	localparam logic [5:0] OP_J     = 6'd2;
	localparam logic [5:0] OP_JAL   = 6'd3;
	localparam logic [5:0] OP_BEQ   = 6'd4;
	localparam logic [5:0] OP_BNE   = 6'd5;
	localparam logic [5:0] OP_ADDI  = 6'd8;
	localparam logic [5:0] OP_ADDIU = 6'd9;
	localparam logic [5:0] OP_SLTI  = 6'd10;
	localparam logic [5:0] OP_SLTIU = 6'd11;
	localparam logic [5:0] OP_ANDI  = 6'd12;
	localparam logic [5:0] OP_ORI   = 6'd13;
	localparam logic [5:0] OP_XORI  = 6'd14;
	localparam logic [5:0] OP_LUI   = 6'd15;
	localparam logic [5:0] OP_LB    = 6'd32;
	localparam logic [5:0] OP_LH    = 6'd33;
	localparam logic [5:0] OP_LW    = 6'd35;
	localparam logic [5:0] OP_LBU   = 6'd36;
	localparam logic [5:0] OP_LHU   = 6'd37;
	localparam logic [5:0] OP_SB    = 6'd40;
	localparam logic [5:0] OP_SH    = 6'd41;
	localparam logic [5:0] OP_SW    = 6'd43;

	// multiply/divide request into the shared unit
	typedef struct packed {
		logic        start;
		logic        is_div;
		logic        signed_op;
		logic [31:0] a;
		logic [31:0] b;
	} md_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] hi;
		logic [31:0] lo;
	} md_rsp_t;

endpackage

### rtl/mieu_muldiv.sv
// iterative shift-add multiplier and restoring divider with a 33-bit add and a 33-bit trial subtract
module mieu_muldiv
	import mieu_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  md_req_t req,
	output md_rsp_t rsp
);

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic        div_q;
	logic        neg_q_q;
	logic        neg_r_q;
	logic [31:0] acc_q;
	logic [31:0] sh_q;
	logic [31:0] m_q;
	logic        done_q;
	logic [31:0] hi_q;
	logic [31:0] lo_q;

	logic [31:0] a_abs;
	logic [31:0] b_abs;
	logic [32:0] sum;
	logic [32:0] trial;
	logic [63:0] prod;
	logic [63:0] prod_fix;

	always_comb begin
		a_abs = (req.signed_op && req.a[31]) ? (32'd0 - req.a) : req.a;
		b_abs = (req.signed_op && req.b[31]) ? (32'd0 - req.b) : req.b;
	end

	// separate add and trial-subtract paths: accumulate for multiply, trial subtract for divide
	always_comb begin
		sum   = {1'b0, acc_q} + {1'b0, (sh_q[0] ? m_q : 32'd0)};
		trial = {acc_q, sh_q[31]} - {1'b0, m_q};
		prod  = {acc_q, sh_q};
		prod_fix = neg_q_q ? (64'd0 - prod) : prod;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q   <= req.is_div;
			acc_q   <= '0;
			sh_q    <= a_abs;
			m_q     <= b_abs;
			neg_q_q <= req.signed_op && (req.a[31] ^ req.b[31]);
			neg_r_q <= req.signed_op && req.a[31];
		end else if (busy_q && cnt_q != 6'd0) begin
			if (div_q) begin
				if (!trial[32]) begin
					acc_q <= trial[31:0];
					sh_q  <= {sh_q[30:0], 1'b1};
				end else begin
					acc_q <= {acc_q[30:0], sh_q[31]};
					sh_q  <= {sh_q[30:0], 1'b0};
				end
			end else begin
				acc_q <= sum[32:1];
				sh_q  <= {sum[0], sh_q[31:1]};
			end
		end else if (busy_q) begin
			if (div_q) begin
				lo_q <= neg_q_q ? (32'd0 - sh_q) : sh_q;
				hi_q <= neg_r_q ? (32'd0 - acc_q) : acc_q;
			end else begin
				hi_q <= prod_fix[63:32];
				lo_q <= prod_fix[31:0];
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.hi   = hi_q;
	assign rsp.lo   = lo_q;

endmodule

### rtl/mips_integer_execute_unit.sv
// top level of the mips32 integer execute unit
// Executes one decoded MIPS32 instruction per transaction and returns one result transaction.
// Each instruction passes through an operand read state and an execute state before its
// result is presented. Loads and stores add a memory state after execute. mult, multu, div
// and divu instead wait in the shared shift-add/subtract unit for its iterations, a sign fix
// and the hand-back of the result. in_stall is high during a clearing pass after reset while
// each of the MEM_WORDS data memory words is zeroed. It is also high from the cycle after
// acceptance until the result has been taken.
module mips_integer_execute_unit
	import mieu_pkg::*;
#(
	parameter int MEM_WORDS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  format,
	input  logic [5:0]  opcode,
	input  logic [4:0]  src_reg,
	input  logic [4:0]  tgt_reg,
	input  logic [4:0]  dst_reg,
	input  logic [4:0]  shift_amount,
	input  logic [15:0] imm16,
	input  logic [25:0] jump_target,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic        reg_written,
	output logic [4:0]  written_index,
	output logic [31:0] written_value,
	output logic [31:0] next_pc
);

	localparam int AW = $clog2(MEM_WORDS);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_READ  = 3'd2;
	localparam logic [2:0] S_EXEC  = 3'd3;
	localparam logic [2:0] S_MEM   = 3'd4;
	localparam logic [2:0] S_MD    = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	logic [2:0]  state_q;
	logic [AW:0] clr_q;

	logic [1:0]  fmt_q;
	logic [5:0]  op_q;
	logic [4:0]  rs_q, rt_q, rd_q, sh_q;
	logic [15:0] imm_q;
	logic [25:0] tgt_q;

	logic [31:0] gpr_q [32];
	logic [31:0] mem_q [MEM_WORDS];
	logic [31:0] a_q, b_q, mw_q;
	logic [31:0] hi_q, lo_q, pc_q;

	logic [1:0]  st_q;
	logic        wr_q;
	logic [4:0]  widx_q;
	logic [31:0] val_q, npc_q;

	md_req_t md_req;
	md_rsp_t md_rsp;

	mieu_muldiv u_md (
		.clk(clk), .arst_n(arst_n), .req(md_req), .rsp(md_rsp)
	);

	logic [31:0] simm, zimm, addr, pc4;
	logic [AW-1:0] widx_mem;
	logic [4:0]  lane, hlane;
	logic [31:0] sum_ab, dif_ab, sum_ai;
	logic [4:0]  vsh;

	always_comb begin
		simm = {{16{imm_q[15]}}, imm_q};
		zimm = {16'd0, imm_q};
		addr = a_q + simm;
		widx_mem = addr[AW+1:2];
		lane  = {addr[1:0], 3'd0};
		hlane = {addr[1], 4'd0};
		pc4 = pc_q + 32'd4;
		sum_ab = a_q + b_q;
		dif_ab = a_q - b_q;
		sum_ai = a_q + simm;
		vsh = a_q[4:0];
	end

	// execute decode: status, next pc and result of the non-memory, non-muldiv instructions, and flags for the rest
	logic [1:0]  x_st;
	logic        x_wr, x_ld, x_sto, x_md, x_sethl;
	logic [4:0]  x_idx;
	logic [31:0] x_val, x_pc, x_hi, x_lo;

	always_comb begin
		x_st = ST_OK; x_wr = 1'b0; x_ld = 1'b0; x_sto = 1'b0; x_md = 1'b0;
		x_sethl = 1'b0; x_idx = 5'd0; x_val = 32'd0; x_pc = pc4;
		x_hi = hi_q; x_lo = lo_q;
		unique case (fmt_q)
			FMT_R: begin
				x_idx = rd_q; x_wr = 1'b1;
				unique case (op_q)
					F_SLL:  x_val = b_q << sh_q;
					F_SRL:  x_val = b_q >> sh_q;
					F_SRA:  x_val = 32'($signed(b_q) >>> sh_q);
					F_SLLV: x_val = b_q << vsh;
					F_SRLV: x_val = b_q >> vsh;
					F_SRAV: x_val = 32'($signed(b_q) >>> vsh);
					F_JR:   begin x_wr = 1'b0; x_pc = a_q; end
					F_JALR: begin x_val = pc4; x_pc = a_q; end
					F_MFHI: x_val = hi_q;
					F_MTHI: begin x_wr = 1'b0; x_sethl = 1'b1; x_hi = a_q; end
					F_MFLO: x_val = lo_q;
					F_MTLO: begin x_wr = 1'b0; x_sethl = 1'b1; x_lo = a_q; end
					F_MULT, F_MULTU: begin x_wr = 1'b0; x_md = 1'b1; end
					F_DIV, F_DIVU: begin
						x_wr = 1'b0;
						if (b_q == 32'd0) x_st = ST_DIV0;
						else x_md = 1'b1;
					end
					F_ADD: begin
						x_val = sum_ab;
						if (~(a_q[31] ^ b_q[31]) & (a_q[31] ^ sum_ab[31])) x_st = ST_OVF;
					end
					F_ADDU: x_val = sum_ab;
					F_SUB: begin
						x_val = dif_ab;
						if ((a_q[31] ^ b_q[31]) & (a_q[31] ^ dif_ab[31])) x_st = ST_OVF;
					end
					F_SUBU: x_val = dif_ab;
					F_AND:  x_val = a_q & b_q;
					F_OR:   x_val = a_q | b_q;
					F_XOR:  x_val = a_q ^ b_q;
					F_NOR:  x_val = ~(a_q | b_q);
					F_SLT:  x_val = {31'd0, $signed(a_q) < $signed(b_q)};
					F_SLTU: x_val = {31'd0, a_q < b_q};
					default: x_st = ST_UNK;
				endcase
			end
			FMT_I: begin
				x_idx = rt_q; x_wr = 1'b1;
				unique case (op_q)
					OP_BEQ: begin
						x_wr = 1'b0;
						if (a_q == b_q) x_pc = pc4 + {simm[29:0], 2'b00};
					end
					OP_BNE: begin
						x_wr = 1'b0;
						if (a_q != b_q) x_pc = pc4 + {simm[29:0], 2'b00};
					end
					OP_ADDI: begin
						x_val = sum_ai;
						if (~(a_q[31] ^ simm[31]) & (a_q[31] ^ sum_ai[31])) x_st = ST_OVF;
					end
					OP_ADDIU: x_val = sum_ai;
					OP_SLTI:  x_val = {31'd0, $signed(a_q) < $signed(simm)};
					OP_SLTIU: x_val = {31'd0, a_q < simm};
					OP_ANDI:  x_val = a_q & zimm;
					OP_ORI:   x_val = a_q | zimm;
					OP_XORI:  x_val = a_q ^ zimm;
					OP_LUI:   x_val = {imm_q, 16'd0};
					OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: x_ld = 1'b1;
					OP_SB, OP_SH, OP_SW: begin x_wr = 1'b0; x_sto = 1'b1; end
					default: x_st = ST_UNK;
				endcase
			end
			FMT_J: begin
				if (op_q == OP_J || op_q == OP_JAL) begin
					if (op_q == OP_JAL) begin x_wr = 1'b1; x_idx = 5'd31; x_val = pc4; end
					x_pc = {pc4[31:28], tgt_q, 2'b00};
				end else begin
					x_st = ST_UNK;
				end
			end
			default: x_st = ST_UNK;
		endcase
	end

	// load data and store merge from the registered memory word
	logic [31:0] ld_val, st_val, byte_w, half_w;
	always_comb begin
		byte_w = (mw_q >> lane) & 32'hFF;
		half_w = (mw_q >> hlane) & 32'hFFFF;
		unique case (op_q)
			OP_LB:   ld_val = {{24{byte_w[7]}}, byte_w[7:0]};
			OP_LH:   ld_val = {{16{half_w[15]}}, half_w[15:0]};
			OP_LBU:  ld_val = byte_w;
			OP_LHU:  ld_val = half_w;
			default: ld_val = mw_q;
		endcase
		unique case (op_q)
			OP_SB:   st_val = (mw_q & ~(32'hFF << lane)) | ((b_q & 32'hFF) << lane);
			OP_SH:   st_val = (mw_q & ~(32'hFFFF << hlane)) | ((b_q & 32'hFFFF) << hlane);
			default: st_val = b_q;
		endcase
	end

	logic in_acc, out_acc;
	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		md_req.start     = (state_q == S_EXEC) && x_md && (x_st == ST_OK);
		md_req.is_div    = (op_q == F_DIV) || (op_q == F_DIVU);
		md_req.signed_op = (op_q == F_MULT) || (op_q == F_DIV);
		md_req.a         = a_q;
		md_req.b         = b_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			hi_q    <= '0;
			lo_q    <= '0;
			pc_q    <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW+1)'(MEM_WORDS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (in_acc) state_q <= S_READ;
				S_READ: state_q <= S_EXEC;
				S_EXEC: begin
					if (x_st != ST_OK) state_q <= S_OUT;
					else if (x_ld || x_sto) state_q <= S_MEM;
					else if (x_md) state_q <= S_MD;
					else begin
						if (x_sethl) begin hi_q <= x_hi; lo_q <= x_lo; end
						pc_q <= x_pc;
						state_q <= S_OUT;
					end
				end
				S_MEM: begin pc_q <= pc4; state_q <= S_OUT; end
				S_MD: if (md_rsp.done) begin
					hi_q <= md_rsp.hi; lo_q <= md_rsp.lo; pc_q <= pc4;
					state_q <= S_OUT;
				end
				S_OUT: if (out_acc) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// memory: one clocked write port, one registered read port
	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR) mem_q[clr_q[AW-1:0]] <= '0;
		else if (state_q == S_MEM && x_sto) mem_q[widx_mem] <= st_val;
		mw_q <= mem_q[widx_mem];
	end

	logic gpr_we;
	assign gpr_we = ((state_q == S_EXEC && x_st == ST_OK && !x_ld && !x_sto && !x_md
		&& x_wr) || (state_q == S_MEM && x_ld)) && x_idx != 5'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 32; i++) gpr_q[i] <= '0;
		end else if (gpr_we) begin
			gpr_q[x_idx] <= (state_q == S_MEM) ? ld_val : x_val;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			fmt_q <= format; op_q <= opcode; rs_q <= src_reg; rt_q <= tgt_reg;
			rd_q <= dst_reg; sh_q <= shift_amount; imm_q <= imm16; tgt_q <= jump_target;
		end
		if (state_q == S_READ) begin
			a_q <= (rs_q == 5'd0) ? 32'd0 : gpr_q[rs_q];
			b_q <= (rt_q == 5'd0) ? 32'd0 : gpr_q[rt_q];
		end
		if (state_q == S_EXEC) begin
			st_q   <= x_st;
			wr_q   <= (x_st == ST_OK) && x_wr && !x_ld && x_idx != 5'd0;
			widx_q <= ((x_st == ST_OK) && x_wr && !x_ld && x_idx != 5'd0) ? x_idx : 5'd0;
			val_q  <= ((x_st == ST_OK) && x_wr && !x_ld && x_idx != 5'd0) ? x_val : 32'd0;
			npc_q  <= (x_st == ST_OK) ? x_pc : pc_q;
		end
		if (state_q == S_MEM) begin
			wr_q   <= x_ld && x_idx != 5'd0;
			widx_q <= (x_ld && x_idx != 5'd0) ? x_idx : 5'd0;
			val_q  <= (x_ld && x_idx != 5'd0) ? ld_val : 32'd0;
			npc_q  <= pc4;
		end
	end

	assign out_valid     = (state_q == S_OUT);
	assign status        = st_q;
	assign reg_written   = wr_q;
	assign written_index = widx_q;
	assign written_value = val_q;
	assign next_pc       = npc_q;

endmodule

### rtl/mieu_checker.sv
// port-level checks for the execute unit, bound to the top level
module mieu_checker
	import mieu_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic        reg_written,
	input logic [4:0]  written_index,
	input logic [31:0] written_value
);

	// a result never waits while a new transaction is taken
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken while result pending");

	// a flagged result never writes a register
	a_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> !reg_written) else $error("flagged write");

	// register zero is never reported as written
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reg_written |-> written_index != 5'd0) else $error("r0 write");

	// accepted input is followed by a busy cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("not busy after accept");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(written_value))
		else $error("result dropped");

endmodule

bind mips_integer_execute_unit mieu_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .status(status),
	.reg_written(reg_written), .written_index(written_index),
	.written_value(written_value)
);
